/* src/stable_priority_queue_top_macros.svh */
// Assertion helpers for the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/spq_pkg.sv */
package spq_pkg;

    // Fixed field widths on the stream ports
    localparam int ACTION_W   = 2;
    localparam int ID_FIELD_W = 8;
    localparam int PRIO_FIELD_W = 8;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE  = 2'd0,
        ACT_POP      = 2'd1,
        ACT_SET_PRIO = 2'd2,
        ACT_NOP      = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_FIELD_W-1:0] priority_req;
        logic [ID_FIELD_W-1:0]   item_id;
        t_action                 action;
    } t_request;

    typedef struct packed {
        t_status               status;
        logic                  at_head;
        logic [ID_FIELD_W-1:0] result_id;
    } t_result;

endpackage

/* src/stable_priority_queue_top.sv */
// Priority ready queue of item ids, highest priority first and first-in first-out
// among equal priorities; the entries live in one single-port-read, single-port-write
// memory that is walked one entry per cycle. A pop is one removal walk over the
// queue; an enqueue or a priority change is a removal walk over the queue, then,
// unless it fails, an insertion walk from the tail; the unused action code does no
// walk. One action is in flight at a time; the next input beat is taken as soon as
// the result reaches the output register, even if it is not yet taken downstream.
// The memory needs no clearing after reset.
`include "stable_priority_queue_top_macros.svh"

module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int ID_WIDTH       = 8,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // action[1:0], item_id[9:2], priority_req[17:10], zero pad [23:18]
    input  logic [spq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // result_id[7:0], at_head[8], status[10:9], zero pad [15:11]
    output logic [spq_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int DW = ID_WIDTH + PRIORITY_WIDTH;

    t_request      w_req;
    logic          w_res_valid;
    logic          w_res_ready;
    t_result       w_res;
    logic          w_ram_wr_en;
    logic [AW-1:0] w_ram_wr_addr;
    logic [DW-1:0] w_ram_wr_data;
    logic          w_ram_rd_en;
    logic [AW-1:0] w_ram_rd_addr;
    logic [DW-1:0] w_ram_rd_data;
    logic          r_m_vld;
    t_result       r_m_res;

    // Unpack the input beat
    assign w_req.action       = t_action'(i_s_axis_tdata[1:0]);
    assign w_req.item_id      = i_s_axis_tdata[9:2];
    assign w_req.priority_req = i_s_axis_tdata[17:10];

    spq_ctrl #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .ID_WIDTH       (ID_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .o_req_ready   (o_s_axis_tready),
        .i_req         (w_req),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_ram_wr_en   (w_ram_wr_en),
        .o_ram_wr_addr (w_ram_wr_addr),
        .o_ram_wr_data (w_ram_wr_data),
        .o_ram_rd_en   (w_ram_rd_en),
        .o_ram_rd_addr (w_ram_rd_addr),
        .i_ram_rd_data (w_ram_rd_data)
    );

    spq_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (w_ram_rd_addr),
        .o_rd_data (w_ram_rd_data)
    );

    // Output register: load a new result whenever the slot is free or drains
    assign w_res_ready = !r_m_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_res <= w_res;
        end
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_res_ready) begin
            r_m_vld <= w_res_valid;
        end
    end

    assign o_m_axis_tvalid = r_m_vld;
    assign o_m_axis_tdata  = M_TDATA_W'({r_m_res.status, r_m_res.at_head, r_m_res.result_id});

    `SPQ_ASSERT_SAME(a_ram_no_collide, i_clk, i_rst_n, w_ram_wr_en && w_ram_rd_en, w_ram_wr_addr != w_ram_rd_addr, "entry memory read and write hit the same address")
    `SPQ_ASSERT_SAME(a_busy_excl, i_clk, i_rst_n, w_res_valid, !o_s_axis_tready, "result pending while input is open")
    `SPQ_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (w_req.action != ACT_NOP), !w_res_valid, "result offered one cycle after accept")
    `SPQ_ASSERT_SAME(a_fail_not_head, i_clk, i_rst_n, o_m_axis_tvalid && (r_m_res.status != ST_OK), !r_m_res.at_head, "failed action flags head")

endmodule

/* src/spq_ram.sv */
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/spq_ctrl.sv */
module spq_ctrl #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int ID_WIDTH       = 8,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    output logic                                  o_req_ready,
    input  spq_pkg::t_request                     i_req,
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output spq_pkg::t_result                      o_res,
    output logic                                  o_ram_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]        o_ram_wr_addr,
    output logic [ID_WIDTH+PRIORITY_WIDTH-1:0]    o_ram_wr_data,
    output logic                                  o_ram_rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]        o_ram_rd_addr,
    input  logic [ID_WIDTH+PRIORITY_WIDTH-1:0]    i_ram_rd_data
);

    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = ID_WIDTH + PRIORITY_WIDTH;
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_INSERT,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    t_action                   r_action, n_action;
    logic [ID_WIDTH-1:0]       r_id, n_id;
    logic [PRIORITY_WIDTH-1:0] r_prio, n_prio;
    logic [CW-1:0]             r_scan, n_scan;
    logic                      r_pend, n_pend;
    logic [AW-1:0]             r_pend_idx, n_pend_idx;
    logic                      r_found, n_found;
    logic [CW-1:0]             r_count, n_count;
    t_result                   r_res, n_res;

    logic [ID_WIDTH-1:0]       w_rd_id;
    logic [PRIORITY_WIDTH-1:0] w_rd_prio;
    logic [ID_WIDTH-1:0]       w_in_id;
    logic                      w_match;
    logic                      w_scan_more;
    logic [CW-1:0]             w_count_after;
    logic [DW-1:0]             w_new_entry;

    assign w_rd_id       = i_ram_rd_data[DW-1 -: ID_WIDTH];
    assign w_rd_prio     = i_ram_rd_data[PRIORITY_WIDTH-1:0];
    assign w_in_id       = ID_WIDTH'(i_req.item_id);
    assign w_new_entry   = {r_id, r_prio};
    assign w_scan_more   = (r_scan < r_count);
    assign w_count_after = r_found ? (r_count - CW'(1)) : r_count;
    // Pop takes the head; the other actions look for their id
    assign w_match       = (r_action == ACT_POP) ? (r_pend_idx == '0) : (w_rd_id == r_id);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_id         = r_id;
        n_prio       = r_prio;
        n_scan       = r_scan;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_found      = r_found;
        n_count      = r_count;
        n_res        = r_res;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = '0;
        o_ram_wr_data = '0;
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                // Latch the request and start the removal scan; the unused code goes straight to done
                if (i_req_valid) begin
                    n_action  = i_req.action;
                    n_id      = w_in_id;
                    n_prio    = PRIORITY_WIDTH'(i_req.priority_req);
                    n_scan    = '0;
                    n_pend    = 1'b0;
                    n_found   = 1'b0;
                    n_res.result_id = ID_FIELD_W'(w_in_id);
                    n_res.at_head   = 1'b0;
                    n_res.status    = ST_OK;
                    n_state = (i_req.action == ACT_NOP) ? S_DONE : S_REMOVE;
                end
            end

            S_REMOVE: begin
                // Read upward; once the entry is found, move each later one down
                if (w_scan_more) begin
                    o_ram_rd_en   = 1'b1;
                    o_ram_rd_addr = r_scan[AW-1:0];
                    n_scan        = r_scan + CW'(1);
                    n_pend        = 1'b1;
                    n_pend_idx    = r_scan[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (!r_found && w_match) begin
                        n_found = 1'b1;
                        if (r_action == ACT_POP) begin
                            n_res.result_id = ID_FIELD_W'(w_rd_id);
                        end
                    end else if (r_found) begin
                        o_ram_wr_en   = 1'b1;
                        o_ram_wr_addr = r_pend_idx - AW'(1);
                        o_ram_wr_data = i_ram_rd_data;
                    end
                end else if (!w_scan_more) begin
                    // Scan done: settle the count and pick the next step
                    n_count = w_count_after;
                    n_scan  = w_count_after;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    if (r_action == ACT_POP) begin
                        if (!r_found) begin
                            n_res.status = ST_EMPTY;
                        end
                    end else if (r_action == ACT_SET_PRIO) begin
                        if (!r_found) begin
                            n_res.status = ST_NOT_FOUND;
                        end else begin
                            n_state = S_INSERT;
                        end
                    end else if (w_count_after == FULL_COUNT) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end

            S_INSERT: begin
                // Read downward from the tail, shift lower priorities up by one
                if (r_scan != '0) begin
                    o_ram_rd_en   = 1'b1;
                    o_ram_rd_addr = AW'(r_scan - CW'(1));
                    n_scan        = r_scan - CW'(1);
                    n_pend        = 1'b1;
                    n_pend_idx    = AW'(r_scan - CW'(1));
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    o_ram_wr_en   = 1'b1;
                    o_ram_wr_addr = r_pend_idx + AW'(1);
                    if (w_rd_prio >= r_prio) begin
                        // Place behind the last entry of equal or higher priority
                        o_ram_wr_data   = w_new_entry;
                        n_count         = r_count + CW'(1);
                        n_res.at_head   = 1'b0;
                        n_pend          = 1'b0;
                        n_state         = S_DONE;
                    end else begin
                        o_ram_wr_data = i_ram_rd_data;
                    end
                end else if (r_scan == '0) begin
                    // Everything moved: the new entry becomes the head
                    o_ram_wr_en   = 1'b1;
                    o_ram_wr_addr = '0;
                    o_ram_wr_data = w_new_entry;
                    n_count       = r_count + CW'(1);
                    n_res.at_head = (r_action == ACT_SET_PRIO) ? 1'b1 : (r_prio != '0);
                    n_state       = S_DONE;
                end
            end

            S_DONE: begin
                // Hold the result until the output stage takes it
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_id       <= n_id;
        r_prio     <= n_prio;
        r_scan     <= n_scan;
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_count <= n_count;
        end
    end

endmodule

/* bench/stable_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module stable_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int QUEUE_SLOTS      = 16;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int DRAIN_CYCLES     = 100;
    localparam int RANDOM_PER_PHASE = 258;
    localparam int ID_POOL_SPAN     = 20;
    localparam int SWEEP_LEN        = 40;

    // Ready-queue predictor: mirrors the queue contents and holds the results owed
    class ready_queue_tracker;
        logic [ID_FIELD_W-1:0]   slot_id [QUEUE_SLOTS];
        logic [PRIO_FIELD_W-1:0] slot_prio [QUEUE_SLOTS];
        int                      depth_used;
        t_result                 results_due [$];
        int                      mismatches;

        // Position of an id in the queue, or -1 when absent
        function int locate(logic [ID_FIELD_W-1:0] id);
            int i;
            for (i = 0; i < depth_used; i++) begin
                if (slot_id[i] == id) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Close the gap left by an entry
        function void drop_entry(int pos);
            int i;
            for (i = pos; i < depth_used - 1; i++) begin
                slot_id[i]   = slot_id[i + 1];
                slot_prio[i] = slot_prio[i + 1];
            end
            depth_used--;
        endfunction

        // Insert behind the last entry of equal or higher priority; caller ensures room
        function int place(logic [ID_FIELD_W-1:0] id, logic [PRIO_FIELD_W-1:0] prio);
            int pos;
            int i;
            pos = 0;
            while (pos < depth_used && slot_prio[pos] >= prio) begin
                pos++;
            end
            for (i = depth_used; i > pos; i--) begin
                slot_id[i]   = slot_id[i - 1];
                slot_prio[i] = slot_prio[i - 1];
            end
            slot_id[pos]   = id;
            slot_prio[pos] = prio;
            depth_used++;
            return pos;
        endfunction

        // Apply one accepted action and queue the result it owes
        function void note_action(t_request req);
            t_result res;
            int      pos;
            res.result_id = req.item_id;
            res.at_head   = 1'b0;
            res.status    = ST_OK;
            case (req.action)
                ACT_ENQUEUE: begin
                    pos = locate(req.item_id);
                    if (pos >= 0) begin
                        drop_entry(pos);
                    end
                    if (depth_used >= QUEUE_SLOTS) begin
                        res.status = ST_FULL;
                    end else begin
                        pos = place(req.item_id, req.priority_req);
                        res.at_head = (pos == 0) && (req.priority_req != '0);
                    end
                end
                ACT_POP: begin
                    if (depth_used == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.result_id = slot_id[0];
                        drop_entry(0);
                    end
                end
                ACT_SET_PRIO: begin
                    pos = locate(req.item_id);
                    if (pos < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        drop_entry(pos);
                        res.at_head = (place(req.item_id, req.priority_req) == 0);
                    end
                end
                default: begin
                end
            endcase
            results_due.push_back(res);
        endfunction

        // Compare an output beat with the oldest result owed
        function void check_result(logic [M_TDATA_W-1:0] beat);
            t_result got;
            t_result want;
            got = t_result'(beat[$bits(t_result)-1:0]);
            if (results_due.size() == 0) begin
                $display("%0t: result beat with no action pending, actual %h", $time, beat);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (got.result_id !== want.result_id) begin
                $display("%0t: result_id expected %h actual %h",
                         $time, want.result_id, got.result_id);
                mismatches++;
            end
            if (got.at_head !== want.at_head) begin
                $display("%0t: at_head expected %b actual %b", $time, want.at_head, got.at_head);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    int                   src_idle_pct   = 0;
    int                   sink_stall_pct = 0;
    int                   cycle_count    = 0;
    ready_queue_tracker   queue_model    = new;

    stable_priority_queue_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at random and check each accepted beat
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            queue_model.check_result(o_m_axis_tdata);
        end
    end

    // Offer one action beat after a random idle gap and hold it until accepted
    task automatic send_action(input t_action act, input logic [ID_FIELD_W-1:0] id,
                               input logic [PRIO_FIELD_W-1:0] prio);
        t_request req;
        req.action       = act;
        req.item_id      = id;
        req.priority_req = prio;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W - $bits(t_request)){1'b0}}, req};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        queue_model.note_action(req);
    endtask

    // Alternate filling and draining sweeps over a small id pool so the queue
    // swings between empty and full, with some ids from the whole range
    task automatic send_random_actions(input int count);
        int                      n;
        int                      roll;
        int                      id_base;
        bit                      filling;
        t_action                 act;
        logic [ID_FIELD_W-1:0]   id;
        logic [PRIO_FIELD_W-1:0] prio;
        id_base = 0;
        for (n = 0; n < count; n++) begin
            if (n % (2 * SWEEP_LEN) == 0) begin
                id_base = $urandom_range(0, 255 - ID_POOL_SPAN);
            end
            filling = ((n / SWEEP_LEN) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 60 : 25)) begin
                act = ACT_ENQUEUE;
            end else if (roll < 75) begin
                act = ACT_POP;
            end else if (roll < 95) begin
                act = ACT_SET_PRIO;
            end else begin
                act = ACT_NOP;
            end
            if ($urandom_range(0, 99) < 80) begin
                id = ID_FIELD_W'(id_base + $urandom_range(0, ID_POOL_SPAN - 1));
            end else begin
                id = ID_FIELD_W'($urandom_range(0, 255));
            end
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                prio = PRIO_FIELD_W'($urandom_range(0, 3));
            end else if (roll < 60) begin
                prio = 8'hFF;
            end else if (roll < 70) begin
                prio = 8'h00;
            end else begin
                prio = PRIO_FIELD_W'($urandom_range(0, 255));
            end
            send_action(act, id, prio);
        end
    endtask

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int phase;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, absent id, unused code, zero priority, ties,
        // re-enqueue of a queued id, promotion above the head, drain to empty
        send_action(ACT_POP, 8'hFF, 8'hFF);
        send_action(ACT_SET_PRIO, 8'h00, 8'h00);
        send_action(ACT_NOP, 8'hA5, 8'h5A);
        send_action(ACT_ENQUEUE, 8'h00, 8'h00);
        send_action(ACT_ENQUEUE, 8'h01, 8'h00);
        send_action(ACT_ENQUEUE, 8'hFF, 8'hFF);
        send_action(ACT_ENQUEUE, 8'h80, 8'hFF);
        send_action(ACT_ENQUEUE, 8'h00, 8'h10);
        send_action(ACT_SET_PRIO, 8'h01, 8'h01);
        send_action(ACT_SET_PRIO, 8'h80, 8'hFF);
        send_action(ACT_POP, 8'h00, 8'h00);
        send_action(ACT_ENQUEUE, 8'h7F, 8'h7F);
        send_action(ACT_POP, 8'h5A, 8'hA5);
        send_action(ACT_SET_PRIO, 8'h01, 8'hFE);
        send_action(ACT_SET_PRIO, 8'h55, 8'h01);
        send_action(ACT_NOP, 8'h00, 8'hFF);
        repeat (4) send_action(ACT_POP, 8'h3C, 8'hC3);

        // Random: no idling, sender idle, receiver stalling, both lightly
        for (phase = 0; phase < 4; phase++) begin
            src_idle_pct   = (phase == 1) ? 73 : (phase == 3) ? 9 : 0;
            sink_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 9 : 0;
            send_random_actions(RANDOM_PER_PHASE);
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain, then allow for stray beats
        while (queue_model.results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (queue_model.mismatches == 0 && queue_model.results_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
